/* rtl/bilinear_wrap_texture_sampler_macros.svh */
// assertion macros for the texture sampler
`ifndef BILINEAR_WRAP_TEXTURE_SAMPLER_MACROS_SVH
`define BILINEAR_WRAP_TEXTURE_SAMPLER_MACROS_SVH

`ifndef NO_ASSERTIONS

// holds at every clock edge out of reset
`define BWTS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent implies consequent on the same edge
`define BWTS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`else

`define BWTS_ASSERT(label, prop, msg)
`define BWTS_ASSERT_IMP(label, ante, cons, msg)

`endif

`endif

/* rtl/bwts_pkg.sv */
package bwts_pkg;

	localparam int MAX_WIDTH    = 256;
	localparam int MAX_HEIGHT   = 256;
	localparam int MAX_CHANNELS = 4;

	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	localparam int COORD_W = 8;
	localparam int DIM_W   = 9;
	localparam int CCNT_W  = 3;
	localparam int FRAC_W  = 8;
	localparam int WGT_W   = 2 * FRAC_W + 1;
	localparam int PROD_W  = FRAC_W + 2 * FRAC_W;
	localparam int CHAN_W  = 16;
	localparam int NUM_CH  = 4;
	localparam int CFG_W   = 9;
	localparam int LATENCY = 4;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 16'd65280;

	typedef enum logic {
		CMD_WRITE  = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH   = 2'd0,
		REG_IMAGE_HEIGHT  = 2'd1,
		REG_CHANNEL_COUNT = 2'd2,
		REG_SMOOTH_MODE   = 2'd3
	} cfg_reg_t;

	// zero counts as one, anything above the limit counts as the limit
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] lim);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > lim) begin
			r = lim;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

/* rtl/bilinear_wrap_texture_sampler.sv */
// Texture sampler with a 256 x 256 store of four 8-bit channels per pixel. A transfer
// (start high, busy low) is a write of one channel byte or a sample. busy never rises:
// one item is taken every cycle, and a sample's result appears on the chan/range_error
// ports with done high for one cycle; writes give no result. Results cannot be held
// off and must be taken when done is high. The pipe has four stages: address, store
// read and weights, channel products, and the sum. The store is kept as two copies,
// each with one write and two read ports, written together, so all four neighbors are
// read in the same cycle. Store entries power up undefined; a smooth sample must only
// touch pixels written since reset, its own and its right, lower and lower-right
// neighbors, while a nearest-pixel sample reads only its own pixel. Configuration is
// written through cfg_write/cfg_index/cfg_data; the user must write it only while no
// transfer is in flight, and the block does not enforce this.
`include "bilinear_wrap_texture_sampler_macros.svh"

module bilinear_wrap_texture_sampler
	import bwts_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [1:0]          cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                start,
	output logic                busy,
	input  logic                command,
	input  logic [COORD_W-1:0]  pixel_x,
	input  logic [COORD_W-1:0]  pixel_y,
	input  logic [FRAC_W-1:0]   frac_x,
	input  logic [FRAC_W-1:0]   frac_y,
	input  logic [1:0]          channel_sel,
	input  logic [7:0]          byte_value,
	output logic                done,
	output logic [CHAN_W-1:0]   chan0,
	output logic [CHAN_W-1:0]   chan1,
	output logic [CHAN_W-1:0]   chan2,
	output logic [CHAN_W-1:0]   chan3,
	output logic                range_error
);

	// configuration
	logic [DIM_W-1:0]  image_width_q;
	logic [DIM_W-1:0]  image_height_q;
	logic [CCNT_W-1:0] channel_count_q;
	logic              smooth_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= DIM_W'(256);
			image_height_q  <= DIM_W'(256);
			channel_count_q <= CCNT_W'(3);
			smooth_mode_q   <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:   image_width_q   <= cfg_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT:  image_height_q  <= cfg_data[DIM_W-1:0];
				REG_CHANNEL_COUNT: channel_count_q <= cfg_data[CCNT_W-1:0];
				REG_SMOOTH_MODE:   smooth_mode_q   <= cfg_data[0];
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 0: bounds, neighbors, weight factors
	logic [DIM_W-1:0]   w_eff, h_eff;
	logic [CCNT_W-1:0]  nch_eff;
	logic               inside_c;
	logic [COORD_W-1:0] x1_c, y1_c;
	logic [FRAC_W-1:0]  fx_c, fy_c;
	logic [NUM_CH-1:0]  chan_en_c;
	logic               xfer;

	assign xfer    = start && !busy;
	assign w_eff   = eff_dim(image_width_q, DIM_W'(MAX_WIDTH));
	assign h_eff   = eff_dim(image_height_q, DIM_W'(MAX_HEIGHT));
	assign nch_eff = (channel_count_q > CCNT_W'(MAX_CHANNELS)) ? CCNT_W'(MAX_CHANNELS)
		: channel_count_q;

	always_comb begin
		inside_c = ({1'b0, pixel_x} < w_eff) && ({1'b0, pixel_y} < h_eff);
		// hard mode is the blend with both fractions zero and every tap on the pixel itself
		if (smooth_mode_q) begin
			x1_c = ({1'b0, pixel_x} == w_eff - DIM_W'(1)) ? '0 : pixel_x + COORD_W'(1);
			y1_c = ({1'b0, pixel_y} == h_eff - DIM_W'(1)) ? '0 : pixel_y + COORD_W'(1);
		end else begin
			x1_c = pixel_x;
			y1_c = pixel_y;
		end
		fx_c = smooth_mode_q ? frac_x : '0;
		fy_c = smooth_mode_q ? frac_y : '0;
		for (int c = 0; c < NUM_CH; c++) begin
			chan_en_c[c] = CCNT_W'(c) < nch_eff;
		end
	end

	logic               valid_s1;
	cmd_t               cmd_s1;
	logic               inside_s1;
	logic [ADDR_W-1:0]  a00_s1, a10_s1, a01_s1, a11_s1;
	logic [FRAC_W-1:0]  fx_s1, fy_s1;
	logic [1:0]         sel_s1;
	logic [7:0]         val_s1;
	logic [NUM_CH-1:0]  chan_en_s1;
	logic [COORD_W-1:0] x1_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= xfer;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1     <= cmd_t'(command);
		inside_s1  <= inside_c;
		a00_s1     <= ADDR_W'(pixel_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(pixel_x);
		a10_s1     <= ADDR_W'(pixel_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x1_c);
		a01_s1     <= ADDR_W'(y1_c) * ADDR_W'(MAX_WIDTH) + ADDR_W'(pixel_x);
		a11_s1     <= ADDR_W'(y1_c) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x1_c);
		fx_s1      <= fx_c;
		fy_s1      <= fy_c;
		sel_s1     <= channel_sel;
		val_s1     <= byte_value;
		chan_en_s1 <= chan_en_c;
		x1_s1      <= x1_c;
	end

	// stage 1: store access and weights
	logic [31:0] store_a_q [STORE_DEPTH];
	logic [31:0] store_b_q [STORE_DEPTH];
	logic        wr_en, rd_en;

	assign wr_en = valid_s1 && (cmd_s1 == CMD_WRITE) && inside_s1
		&& ({1'b0, sel_s1} < 3'(MAX_CHANNELS));
	assign rd_en = valid_s1 && (cmd_s1 == CMD_SAMPLE) && inside_s1;

	logic [31:0] p00_s2, p10_s2, p01_s2, p11_s2;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_a_q[a00_s1][8*sel_s1 +: 8] <= val_s1;
		end
		if (rd_en) begin
			p00_s2 <= store_a_q[a00_s1];
			p10_s2 <= store_a_q[a10_s1];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_b_q[a00_s1][8*sel_s1 +: 8] <= val_s1;
		end
		if (rd_en) begin
			p01_s2 <= store_b_q[a01_s1];
			p11_s2 <= store_b_q[a11_s1];
		end
	end

	logic [FRAC_W:0] ix_c, iy_c;
	assign ix_c = (FRAC_W+1)'(256) - {1'b0, fx_s1};
	assign iy_c = (FRAC_W+1)'(256) - {1'b0, fy_s1};

	logic              valid_s2;
	cmd_t              cmd_s2;
	logic              inside_s2;
	logic [WGT_W-1:0]  w00_s2, w10_s2, w01_s2, w11_s2;
	logic [NUM_CH-1:0] chan_en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s2     <= cmd_s1;
		inside_s2  <= inside_s1;
		w00_s2     <= WGT_W'(ix_c) * WGT_W'(iy_c);
		w10_s2     <= WGT_W'(fx_s1) * WGT_W'(iy_c);
		w01_s2     <= WGT_W'(ix_c) * WGT_W'(fy_s1);
		w11_s2     <= WGT_W'(fx_s1) * WGT_W'(fy_s1);
		chan_en_s2 <= chan_en_s1;
	end

	// stage 2: per-channel products
	logic              valid_s3;
	cmd_t              cmd_s3;
	logic              inside_s3;
	logic [NUM_CH-1:0] chan_en_s3;
	logic [PROD_W-1:0] m00_s3 [NUM_CH];
	logic [PROD_W-1:0] m10_s3 [NUM_CH];
	logic [PROD_W-1:0] m01_s3 [NUM_CH];
	logic [PROD_W-1:0] m11_s3 [NUM_CH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s3     <= cmd_s2;
		inside_s3  <= inside_s2;
		chan_en_s3 <= chan_en_s2;
		for (int c = 0; c < NUM_CH; c++) begin
			m00_s3[c] <= PROD_W'(p00_s2[8*c +: 8]) * PROD_W'(w00_s2);
			m10_s3[c] <= PROD_W'(p10_s2[8*c +: 8]) * PROD_W'(w10_s2);
			m01_s3[c] <= PROD_W'(p01_s2[8*c +: 8]) * PROD_W'(w01_s2);
			m11_s3[c] <= PROD_W'(p11_s2[8*c +: 8]) * PROD_W'(w11_s2);
		end
	end

	// stage 3: sum, scale, mask
	logic [PROD_W-1:0] sum_c [NUM_CH];
	logic [CHAN_W-1:0] res_c [NUM_CH];

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			sum_c[c] = m00_s3[c] + m10_s3[c] + m01_s3[c] + m11_s3[c];
			res_c[c] = (inside_s3 && chan_en_s3[c]) ? sum_c[c][PROD_W-1:8] : '0;
		end
	end

	logic              done_q;
	logic [CHAN_W-1:0] chan_q [NUM_CH];
	logic              range_error_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s3 && (cmd_s3 == CMD_SAMPLE);
		end
	end

	always_ff @(posedge clk) begin
		range_error_q <= !inside_s3;
		for (int c = 0; c < NUM_CH; c++) begin
			chan_q[c] <= res_c[c];
		end
	end

	assign done        = done_q;
	assign chan0       = chan_q[0];
	assign chan1       = chan_q[1];
	assign chan2       = chan_q[2];
	assign chan3       = chan_q[3];
	assign range_error = range_error_q;

	`BWTS_ASSERT_IMP(a_err_zero, done && range_error,
		(chan0 == '0) && (chan1 == '0) && (chan2 == '0) && (chan3 == '0),
		"range error with nonzero channel")
	`BWTS_ASSERT_IMP(a_chan_max, done,
		(chan0 <= CHAN_MAX) && (chan1 <= CHAN_MAX) && (chan2 <= CHAN_MAX)
		&& (chan3 <= CHAN_MAX), "channel result above full scale")
	`BWTS_ASSERT_IMP(a_write_silent, $past(xfer && (command == CMD_WRITE), LATENCY),
		!done, "write produced a result")
	`BWTS_ASSERT_IMP(a_wrap_inside, valid_s1 && inside_s1,
		{1'b0, x1_s1} < w_eff, "wrapped column outside image")
	`BWTS_ASSERT_IMP(a_weight_sum, valid_s2,
		(w00_s2 + w10_s2 + w01_s2 + w11_s2) == WGT_W'(65536),
		"bilinear weights do not sum to one")

endmodule

/* tb/testbench.sv */
module testbench;
	import bwts_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 40;
	localparam int HOT_MAX     = 64;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] fx;
		logic [7:0] fy;
		logic [1:0] sel;
		logic [7:0] val;
	} texture_op_t;

	typedef struct packed {
		logic [NUM_CH-1:0][CHAN_W-1:0] chan;
		logic                          range_error;
	} texel_result_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_write   = 1'b0;
	logic [1:0]         cfg_index   = REG_IMAGE_WIDTH;
	logic [CFG_W-1:0]   cfg_data    = '0;
	logic               start       = 1'b0;
	logic               busy;
	logic               command     = CMD_WRITE;
	logic [COORD_W-1:0] pixel_x     = '0;
	logic [COORD_W-1:0] pixel_y     = '0;
	logic [FRAC_W-1:0]  frac_x      = '0;
	logic [FRAC_W-1:0]  frac_y      = '0;
	logic [1:0]         channel_sel = '0;
	logic [7:0]         byte_value  = '0;
	logic               done;
	logic [CHAN_W-1:0]  chan0, chan1, chan2, chan3;
	logic               range_error;

	texture_op_t   op_q[$];
	texel_result_t expected_q[$];
	int            backlog     = 0;
	logic          took_item   = 1'b0;
	int            gap_left    = 0;
	int            gap_max     = 17;
	int            error_count = 0;

	// predictor copy of the texture and registers
	logic [31:0]       texel_mem [0:STORE_DEPTH-1];
	logic [DIM_W-1:0]  reg_width;
	logic [DIM_W-1:0]  reg_height;
	logic [CCNT_W-1:0] reg_channels;
	logic              reg_smooth;

	// stimulus side view of which bytes hold data
	logic [3:0] byte_planned [0:STORE_DEPTH-1];
	int         plan_w;
	int         plan_h;
	int         hot_spots[$];
	int         item_count;

	bilinear_wrap_texture_sampler dut (.*);

	initial forever #6 clk = ~clk;

	function automatic int clamp_dim(int v, int lim);
		if (v == 0)
			return 1;
		if (v > lim)
			return lim;
		return v;
	endfunction

	function automatic texel_result_t filter_texel(texture_op_t op);
		texel_result_t res;
		int w, h, nch, x1, y1, acc, fxi, fyi;
		int wt [4];
		logic [31:0] px [4];
		res = '0;
		w = clamp_dim(reg_width, MAX_WIDTH);
		h = clamp_dim(reg_height, MAX_HEIGHT);
		nch = (reg_channels > MAX_CHANNELS) ? MAX_CHANNELS : reg_channels;
		if (op.x >= w || op.y >= h) begin
			res.range_error = 1'b1;
			return res;
		end
		fxi = op.fx;
		fyi = op.fy;
		x1 = (op.x == w - 1) ? 0 : op.x + 1;
		y1 = (op.y == h - 1) ? 0 : op.y + 1;
		px[0] = texel_mem[op.y * MAX_WIDTH + op.x];
		if (reg_smooth) begin
			px[1] = texel_mem[op.y * MAX_WIDTH + x1];
			px[2] = texel_mem[y1 * MAX_WIDTH + op.x];
			px[3] = texel_mem[y1 * MAX_WIDTH + x1];
			wt[0] = (256 - fxi) * (256 - fyi);
			wt[1] = fxi * (256 - fyi);
			wt[2] = (256 - fxi) * fyi;
			wt[3] = fxi * fyi;
		end
		for (int c = 0; c < nch; c++) begin
			if (reg_smooth) begin
				acc = 0;
				for (int k = 0; k < 4; k++)
					acc += int'(px[k][8 * c +: 8]) * wt[k];
				res.chan[c] = CHAN_W'(acc >> 8);
			end else begin
				res.chan[c] = {px[0][8 * c +: 8], 8'h00};
			end
		end
		return res;
	endfunction

	function automatic void store_byte(texture_op_t op);
		int w, h;
		w = clamp_dim(reg_width, MAX_WIDTH);
		h = clamp_dim(reg_height, MAX_HEIGHT);
		if (op.x < w && op.y < h && op.sel < MAX_CHANNELS)
			texel_mem[op.y * MAX_WIDTH + op.x][8 * op.sel +: 8] = op.val;
	endfunction

	function automatic void flag_error(string msg);
		error_count++;
		if (error_count <= 10)
			$display("%0t mismatch: %s", $time, msg);
	endfunction

	// stimulus helpers
	function automatic void plan_write(int x, int y, int sel, int val);
		texture_op_t op;
		op = '0;
		op.cmd = CMD_WRITE;
		op.x = 8'(x);
		op.y = 8'(y);
		op.fx = 8'($urandom);
		op.fy = 8'($urandom);
		op.sel = 2'(sel);
		op.val = 8'(val);
		op_q.push_back(op);
		if (x < plan_w && y < plan_h) begin
			byte_planned[y * MAX_WIDTH + x][sel] = 1'b1;
			item_count++;
		end
	endfunction

	function automatic void plan_pixel(int x, int y, logic [31:0] word);
		for (int c = 0; c < 4; c++)
			plan_write(x, y, c, word[8 * c +: 8]);
	endfunction

	// every byte of the 2x2 neighborhood must hold data before a sample reads it
	function automatic void prime_block(int x, int y);
		int xs [2];
		int ys [2];
		int addr;
		xs[0] = x;
		xs[1] = (x == plan_w - 1) ? 0 : x + 1;
		ys[0] = y;
		ys[1] = (y == plan_h - 1) ? 0 : y + 1;
		for (int j = 0; j < 2; j++)
			for (int i = 0; i < 2; i++) begin
				addr = ys[j] * MAX_WIDTH + xs[i];
				for (int c = 0; c < 4; c++)
					if (!byte_planned[addr][c])
						plan_write(xs[i], ys[j], c, $urandom_range(0, 255));
			end
	endfunction

	function automatic void plan_sample(int x, int y, int fx, int fy);
		texture_op_t op;
		if (x < plan_w && y < plan_h) begin
			prime_block(x, y);
			if (hot_spots.size() < HOT_MAX)
				hot_spots.push_back(y * MAX_WIDTH + x);
		end
		op = '0;
		op.cmd = CMD_SAMPLE;
		op.x = 8'(x);
		op.y = 8'(y);
		op.fx = 8'(fx);
		op.fy = 8'(fy);
		op.sel = 2'($urandom);
		op.val = 8'($urandom);
		op_q.push_back(op);
		item_count++;
	endfunction

	function automatic int pick_edge(int n);
		case ($urandom_range(0, 2))
			0: return 0;
			1: return n - 1;
			default: return $urandom_range(0, n - 1);
		endcase
	endfunction

	function automatic int pick_frac();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 255;
			2: return 128;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	function automatic void outside_coord(output int x, output int y);
		if (plan_w < MAX_WIDTH && (plan_h == MAX_HEIGHT || $urandom_range(0, 1) == 1)) begin
			x = $urandom_range(plan_w, 255);
			y = $urandom_range(0, 255);
		end else begin
			x = $urandom_range(0, 255);
			y = $urandom_range(plan_h, 255);
		end
	endfunction

	function automatic void random_write();
		int x, y;
		if ($urandom_range(0, 3) != 0 || (plan_w == MAX_WIDTH && plan_h == MAX_HEIGHT)) begin
			x = $urandom_range(0, plan_w - 1);
			y = $urandom_range(0, plan_h - 1);
		end else begin
			outside_coord(x, y);
		end
		plan_write(x, y, $urandom_range(0, 3), $urandom_range(0, 255));
	endfunction

	function automatic void random_sample();
		int x, y, r, spot;
		r = $urandom_range(0, 99);
		if (r < 15 && (plan_w < MAX_WIDTH || plan_h < MAX_HEIGHT)) begin
			outside_coord(x, y);
		end else if (r < 55 && hot_spots.size() > 0) begin
			spot = hot_spots[$urandom_range(0, hot_spots.size() - 1)];
			x = spot % MAX_WIDTH;
			y = spot / MAX_WIDTH;
		end else if (r < 75) begin
			x = pick_edge(plan_w);
			y = pick_edge(plan_h);
		end else begin
			x = $urandom_range(0, plan_w - 1);
			y = $urandom_range(0, plan_h - 1);
		end
		plan_sample(x, y, pick_frac(), pick_frac());
	endfunction

	task automatic wait_idle();
		do
			@(posedge clk);
		while (op_q.size() != 0 || start || backlog != 0);
		// writes give no result and may still be in the pipe
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic set_config(int w, int h, int c, int s);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= CFG_W'(w);
		@(negedge clk);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_data <= CFG_W'(h);
		@(negedge clk);
		cfg_index <= REG_CHANNEL_COUNT;
		cfg_data <= {6'($urandom), 3'(c)};
		@(negedge clk);
		cfg_index <= REG_SMOOTH_MODE;
		cfg_data <= {8'($urandom), 1'(s)};
		@(negedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		plan_w = clamp_dim(w & 'h1ff, MAX_WIDTH);
		plan_h = clamp_dim(h & 'h1ff, MAX_HEIGHT);
	endtask

	// driver
	always @(negedge clk) begin
		texture_op_t next_op;
		if (arst_n && !(start && !took_item)) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (op_q.size() > 0) begin
				next_op = op_q.pop_front();
				command <= next_op.cmd;
				pixel_x <= next_op.x;
				pixel_y <= next_op.y;
				frac_x <= next_op.fx;
				frac_y <= next_op.fy;
				channel_sel <= next_op.sel;
				byte_value <= next_op.val;
				start <= 1'b1;
				gap_left = $urandom_range(0, gap_max);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor and predictor
	always @(posedge clk or negedge arst_n) begin
		texel_result_t got, want;
		texture_op_t   accepted_op;
		if (!arst_n) begin
			took_item <= 1'b0;
			backlog <= 0;
			reg_width <= DIM_W'(256);
			reg_height <= DIM_W'(256);
			reg_channels <= CCNT_W'(3);
			reg_smooth <= 1'b0;
		end else begin
			if (done) begin
				got.chan = {chan3, chan2, chan1, chan0};
				got.range_error = range_error;
				if (expected_q.size() == 0) begin
					flag_error("result with no sample outstanding");
				end else begin
					want = expected_q.pop_front();
					for (int c = 0; c < NUM_CH; c++)
						if (got.chan[c] !== want.chan[c])
							flag_error($sformatf("chan%0d expected %0d got %0d",
								c, want.chan[c], got.chan[c]));
					if (got.range_error !== want.range_error)
						flag_error($sformatf("range_error expected %0b got %0b",
							want.range_error, got.range_error));
				end
			end
			if (start && !busy) begin
				accepted_op.cmd = cmd_t'(command);
				accepted_op.x = pixel_x;
				accepted_op.y = pixel_y;
				accepted_op.fx = frac_x;
				accepted_op.fy = frac_y;
				accepted_op.sel = channel_sel;
				accepted_op.val = byte_value;
				if (accepted_op.cmd == CMD_SAMPLE)
					expected_q.push_back(filter_texel(accepted_op));
				else
					store_byte(accepted_op);
			end
			took_item <= start && !busy;
			if (cfg_write) begin
				case (cfg_index)
					REG_IMAGE_WIDTH:   reg_width <= cfg_data[DIM_W-1:0];
					REG_IMAGE_HEIGHT:  reg_height <= cfg_data[DIM_W-1:0];
					REG_CHANNEL_COUNT: reg_channels <= cfg_data[CCNT_W-1:0];
					REG_SMOOTH_MODE:   reg_smooth <= cfg_data[0];
					default: ;
				endcase
			end
			backlog <= expected_q.size();
		end
	end

	// watchdog on cycles with neither a transfer nor a result
	initial begin
		int stall_cycles;
		stall_cycles = 0;
		wait (arst_n === 1'b1);
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int phase_w [PHASES];
		int phase_h [PHASES];
		int phase_c [PHASES];
		int phase_s [PHASES];
		phase_w = '{256, 1, 0, 511, 2, 256, 37, 300, 255, 16, 256, 129};
		phase_h = '{256, 256, 1, 0, 511, 2, 255, 64, 9, 400, 3, 256};
		phase_c = '{4, 0, 1, 2, 3, 7, 5, 4, 1, 3, 6, 2};
		phase_s = '{1, 0, 1, 1, 0, 1, 0, 1, 1, 0, 1, 1};
		for (int i = 0; i < STORE_DEPTH; i++)
			byte_planned[i] = '0;
		plan_w = MAX_WIDTH;
		plan_h = MAX_HEIGHT;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: full image, three channels, nearest pixel
		plan_pixel(0, 0, 32'hFFFF_FFFF);
		plan_pixel(255, 0, 32'h0000_0000);
		plan_pixel(0, 255, 32'h7FFE_0180);
		plan_pixel(255, 255, 32'hAA55_FF00);
		plan_sample(255, 255, 255, 255);
		plan_sample(255, 255, 0, 0);

		// blend across both wrap edges
		wait_idle();
		set_config(256, 256, 4, 1);
		plan_sample(255, 255, 0, 0);
		plan_sample(255, 255, 255, 255);
		plan_sample(255, 255, 128, 64);

		// zero size counts as a single pixel
		wait_idle();
		set_config(0, 0, 7, 1);
		plan_sample(0, 0, 200, 100);
		plan_sample(1, 0, 0, 0);
		plan_sample(0, 255, 0, 0);
		plan_write(5, 5, 2, 8'h11);
		plan_write(0, 0, 3, 8'h5A);
		plan_sample(0, 0, 255, 255);

		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			set_config(phase_w[p], phase_h[p], phase_c[p], phase_s[p]);
			gap_max = (p % 4 == 2) ? 0 : 17;
			item_count = 0;
			while (item_count < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 20)
					random_write();
				else
					random_sample();
			end
		end

		wait_idle();
		if (expected_q.size() != 0)
			flag_error("samples left without a result");
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
